// ----- rtl/core/aes_pkg.sv -----
// AES-128 shared package: S-box table, GF helpers, round and key-step functions.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps
package aes_pkg;

   localparam int NumRounds = 10;

   typedef logic [127:0] block_type;
   typedef logic [7:0]   byte_type;
   typedef logic [31:0]  word_type;

   localparam logic [0:0] CsrKeyHigh = 1'b0;
   localparam logic [0:0] CsrKeyLow  = 1'b1;

   localparam logic [7:0] SBOX [0:255] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] RCON [0:NumRounds-1] = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   // byte n of the block sits at bits [127-8n -: 8]
   function automatic byte_type get_byte(input block_type b, input int n);
      return b[127-8*n -: 8];
   endfunction

   function automatic byte_type xtime(input byte_type v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic word_type sub_word(input word_type w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // next round key; rc is the round constant of that round
   function automatic block_type key_step(input block_type k, input byte_type rc);
      word_type w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t  = sub_word({w3[23:0], w3[31:24]}) ^ {rc, 24'h0};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   // SubBytes, ShiftRows, optional MixColumns, AddRoundKey
   function automatic block_type round_fn(input block_type s, input block_type k,
                                          input logic mix);
      block_type t;
      block_type m;
      byte_type  a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(t, 4*c);
         a1 = get_byte(t, 4*c+1);
         a2 = get_byte(t, 4*c+2);
         a3 = get_byte(t, 4*c+3);
         m[127-8*(4*c)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         m[127-8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         m[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         m[127-8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return (mix ? m : t) ^ k;
   endfunction

endpackage

// ----- rtl/core/aes_round_stage.sv -----
// One pipeline stage: a cipher round plus the matching key-schedule step.
// Depends on aes_pkg.
`timescale 1ns / 1ps
module aes_round_stage #(
   parameter int Round = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               valid_in,
   input  aes_pkg::block_type state_in,
   input  aes_pkg::block_type key_in,
   output logic               valid_out,
   output aes_pkg::block_type state_out,
   output aes_pkg::block_type key_out
);

   logic               valid_ff;
   aes_pkg::block_type state_ff, state_next_in;
   aes_pkg::block_type key_ff, key_next_in;

   always_comb begin
      key_next_in   = aes_pkg::key_step(key_in, aes_pkg::RCON[Round-1]);
      state_next_in = aes_pkg::round_fn(state_in, key_next_in,
                                        (Round != aes_pkg::NumRounds));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= state_next_in;
         key_ff   <= key_next_in;
      end
   end

   assign valid_out = valid_ff;
   assign state_out = state_ff;
   assign key_out   = key_ff;

endmodule

// ----- rtl/core/aes128_block_encrypt.sv -----
// AES-128 encryption top level: key registers, input stage, ten round stages.
// Depends on aes_pkg and aes_round_stage.
`timescale 1ns / 1ps
// Usage:
//   Write key_high (index 0) and key_low (index 1) on the csr_ port while idle.
//   Plaintext words enter on req_valid/req_stall, ciphertext words leave on
//   rsp_valid/rsp_stall; a word moves when valid is high and stall is low.
//   Pipeline: one input stage with the initial AddRoundKey, then one
//   register stage per round, round key expanded alongside the data in
//   each stage.
//   Throughput: one word per cycle while no stall holds the pipe; each
//   stage holds one block, so eleven blocks can be in flight.
//   Stall: a stage advances when empty or when the next stage does, the
//   last stage when empty or being taken; req_stall is high only when
//   every stage is full and rsp_stall is high; nothing is dropped or duplicated.
//   Bubbles are compressed: an empty stage still fills while downstream waits.
//   Reset: clears all valid bits and both key registers to zero.
//   Keys are sampled at the input stage, so a block never mixes keys.
module aes128_block_encrypt (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_plain_high,
   input  logic [63:0] req_plain_low,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_cipher_high,
   output logic [63:0] rsp_cipher_low
);

   localparam int N = aes_pkg::NumRounds;

   logic [63:0] key_high_ff, key_low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            aes_pkg::CsrKeyHigh: key_high_ff <= csr_data;
            aes_pkg::CsrKeyLow:  key_low_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // stage chain: index 0 is the input stage, index N the output
   logic               vld   [0:N];
   aes_pkg::block_type st    [0:N];
   aes_pkg::block_type rk    [0:N];
   logic               adv   [0:N];

   // per-stage advance: a stage loads if it is empty or the stage after it loads
   always_comb begin
      adv[N] = !vld[N] || !rsp_stall;
      for (int i = N-1; i >= 0; i--) begin
         adv[i] = adv[i+1] || !vld[i];
      end
   end

   assign req_stall = !adv[0];

   logic               in_valid_ff;
   aes_pkg::block_type in_state_ff, in_key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv[0]) begin
         in_valid_ff <= req_valid;
      end
   end

   // initial AddRoundKey in the input stage
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         in_state_ff <= {req_plain_high, req_plain_low} ^ {key_high_ff, key_low_ff};
         in_key_ff   <= {key_high_ff, key_low_ff};
      end
   end

   assign vld[0] = in_valid_ff;
   assign st[0]  = in_state_ff;
   assign rk[0]  = in_key_ff;

   for (genvar g = 1; g <= N; g++) begin : g_round
      aes_round_stage #(.Round(g)) u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (adv[g]),
         .valid_in  (vld[g-1]),
         .state_in  (st[g-1]),
         .key_in    (rk[g-1]),
         .valid_out (vld[g]),
         .state_out (st[g]),
         .key_out   (rk[g])
      );
   end

   assign rsp_valid       = vld[N];
   assign rsp_cipher_high = st[N][127:64];
   assign rsp_cipher_low  = st[N][63:0];

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cipher_high)
                                 && $stable(rsp_cipher_low))
      else $error("result changed under stall");

   // input only stalls when the output is stalled with data
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   // an accepted word reaches the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> in_valid_ff)
      else $error("accepted word lost");

endmodule
